### rtl/wphf_pkg.sv
// ----------------------------------------------------------------------------
// Windowed peak-hold filter package
// Shared widths, register indexes, mode codes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package wphf_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned CIDX_W = 2;

    // Filter modes; the unused code behaves as windowed maximum
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEV = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CIDX_W-1:0] REG_VISIBLE   = 2'd2;

    // Item functions
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Bucket defaults and register reset values
    localparam logic [DATA_W-1:0] DFLT_MIN      = 16'hffff;
    localparam logic [DATA_W-1:0] DFLT_MAX      = 16'h0000;
    localparam logic [DATA_W-1:0] THRESHOLD_RST = 16'd2048;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] threshold;
        logic [DATA_W-1:0] period;
    } t_cfg;

endpackage

`default_nettype wire

### rtl/wphf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds mode and threshold, and turns the window length into the bucket
// period with a constant reciprocal multiply at write time.
// ----------------------------------------------------------------------------
`default_nettype none

module wphf_cfg_regs #(
    parameter int unsigned BUCKETS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr,
    input  wire logic [wphf_pkg::CIDX_W-1:0]       i_index,
    input  wire logic [wphf_pkg::DATA_W-1:0]       i_data,
    output wphf_pkg::t_cfg                         o_cfg
);

    localparam int unsigned LG     = $clog2(BUCKETS);
    localparam int unsigned SHIFT  = wphf_pkg::DATA_W + LG;
    localparam int unsigned PROD_W = SHIFT + wphf_pkg::DATA_W;
    // ceil(2^SHIFT / BUCKETS) gives an exact quotient for every 16-bit value
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + BUCKETS - 1) / BUCKETS;
    localparam logic [wphf_pkg::DATA_W:0] RECIP = RECIP_L[wphf_pkg::DATA_W:0];

    logic [wphf_pkg::MODE_W-1:0] r_mode;
    logic [wphf_pkg::DATA_W-1:0] r_threshold;
    logic [wphf_pkg::DATA_W-1:0] r_period;
    logic [PROD_W-1:0]           n_prod;

    // Scale the written window length by the reciprocal of the bucket count
    assign n_prod = {{SHIFT{1'b0}}, i_data} * {{(SHIFT-1){1'b0}}, RECIP};

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wphf_pkg::MODE_MIN;
            r_threshold <= wphf_pkg::THRESHOLD_RST;
            r_period    <= '0;
        end else if (i_wr) begin
            case (i_index)
                wphf_pkg::REG_MODE:      r_mode      <= i_data[wphf_pkg::MODE_W-1:0];
                wphf_pkg::REG_THRESHOLD: r_threshold <= i_data;
                wphf_pkg::REG_VISIBLE:   r_period    <= n_prod[SHIFT +: wphf_pkg::DATA_W];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.mode      = r_mode;
    assign o_cfg.threshold = r_threshold;
    assign o_cfg.period    = r_period;

endmodule

`default_nettype wire

### rtl/wphf_peak_tree.sv
// ----------------------------------------------------------------------------
// Peak comparator tree
// Balanced min or max tree over the folded sample and all bucket values.
// ----------------------------------------------------------------------------
`default_nettype none

module wphf_peak_tree #(
    parameter int unsigned N = 9
) (
    input  wire logic                        i_is_min,
    input  wire logic [wphf_pkg::DATA_W-1:0] i_vals [N],
    output      logic [wphf_pkg::DATA_W-1:0] o_peak
);

    localparam int unsigned LEAVES = 1 << $clog2(N);

    logic [wphf_pkg::DATA_W-1:0] node [1:2*LEAVES-1];
    logic [wphf_pkg::DATA_W-1:0] pad;

    // Unused leaves hold the neutral value of the selected operation
    assign pad = i_is_min ? wphf_pkg::DFLT_MIN : wphf_pkg::DFLT_MAX;

    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < N) begin : g_val
            assign node[LEAVES+i] = i_vals[i];
        end else begin : g_pad
            assign node[LEAVES+i] = pad;
        end
    end

    // Reduce pairwise toward the root
    for (genvar j = 1; j < LEAVES; j++) begin : g_node
        assign node[j] = i_is_min
            ? ((node[2*j] < node[2*j+1]) ? node[2*j] : node[2*j+1])
            : ((node[2*j] > node[2*j+1]) ? node[2*j] : node[2*j+1]);
    end

    assign o_peak = node[1];

endmodule

`default_nettype wire

### rtl/windowed_peak_hold_filter.sv
// ----------------------------------------------------------------------------
// Windowed peak-hold filter
// An item is held in the input register and a sample's result in the result
// register. Throughput: one item per cycle unless an untaken result stalls;
// the bucket comparator tree and ring update settle between the two registers.
// Reset: synchronous; buckets, index and schedule clear to zero, mode to
// windowed minimum, threshold to 2048, bucket period to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_peak_hold_filter #(
    parameter int unsigned BUCKETS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration write channel
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [wphf_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [wphf_pkg::DATA_W-1:0] i_cfg_data,
    // Input item channel
    input  wire logic                        i_in_valid,
    output      logic                        o_in_ready,
    input  wire logic                        i_func,
    input  wire logic [wphf_pkg::DATA_W-1:0] i_sample,
    input  wire logic [wphf_pkg::TIME_W-1:0] i_now_ms,
    // Result channel
    output      logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    output      logic [wphf_pkg::DATA_W-1:0] o_window_value
);

    localparam int unsigned IW = $clog2(BUCKETS);

    wphf_pkg::t_cfg cfg;

    logic                        r_in_vld;
    logic                        r_in_func;
    logic [wphf_pkg::DATA_W-1:0] r_in_sample;
    logic [wphf_pkg::TIME_W-1:0] r_in_now;

    logic [wphf_pkg::DATA_W-1:0] r_bucket [BUCKETS];
    logic [IW-1:0]               r_idx;
    logic [wphf_pkg::TIME_W-1:0] r_next;

    logic                        r_out_vld;
    logic [wphf_pkg::DATA_W-1:0] r_out_data;

    logic                        proc;
    logic                        do_sample;
    logic                        do_restart;
    logic                        is_min;
    logic [wphf_pkg::DATA_W-1:0] dflt;
    logic [wphf_pkg::DATA_W-1:0] v;
    logic                        fold;
    logic                        adv;
    logic [IW-1:0]               n_idx_adv;
    logic [wphf_pkg::TIME_W-1:0] n_next;
    logic [wphf_pkg::DATA_W-1:0] tree_in [BUCKETS+1];
    logic [wphf_pkg::DATA_W-1:0] peak;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    wphf_cfg_regs #(
        .BUCKETS (BUCKETS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Process the held item when its result has room; a restart needs none
    assign proc       = r_in_vld && (r_in_func || !r_out_vld || i_out_ready);
    assign do_sample  = proc && (r_in_func == wphf_pkg::FUNC_SAMPLE);
    assign do_restart = proc && (r_in_func == wphf_pkg::FUNC_RESTART);
    assign o_in_ready = !r_in_vld || proc;

    assign is_min = (cfg.mode == wphf_pkg::MODE_MIN);
    assign dflt   = is_min ? wphf_pkg::DFLT_MIN : wphf_pkg::DFLT_MAX;

    // Transform sample to absolute deviation in threshold mode
    always_comb begin
        v = r_in_sample;
        if (cfg.mode == wphf_pkg::MODE_DEV) begin
            v = (r_in_sample >= cfg.threshold) ? (r_in_sample - cfg.threshold)
                                               : (cfg.threshold - r_in_sample);
        end
    end

    assign fold = is_min ? (v < r_bucket[r_idx]) : (v > r_bucket[r_idx]);

    // Advance schedule
    assign adv       = (r_next <= r_in_now);
    assign n_idx_adv = (r_idx == IW'(BUCKETS - 1)) ? '0 : r_idx + 1'b1;
    assign n_next    = r_in_now + {{(wphf_pkg::TIME_W-wphf_pkg::DATA_W){1'b0}}, cfg.period};

    // Peak over sample and all buckets
    assign tree_in[0] = v;
    for (genvar k = 0; k < BUCKETS; k++) begin : g_tree_in
        assign tree_in[k+1] = r_bucket[k];
    end

    wphf_peak_tree #(
        .N (BUCKETS + 1)
    ) u_tree (
        .i_is_min (is_min),
        .i_vals   (tree_in),
        .o_peak   (peak)
    );

    // Capture input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_func   <= i_func;
            r_in_sample <= i_sample;
            r_in_now    <= i_now_ms;
        end
    end

    // Update bucket ring, index and schedule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BUCKETS; k++) begin
                r_bucket[k] <= '0;
            end
            r_idx  <= '0;
            r_next <= '0;
        end else if (do_restart) begin
            for (int k = 0; k < BUCKETS; k++) begin
                r_bucket[k] <= dflt;
            end
            r_idx  <= '0;
            r_next <= n_next;
        end else if (do_sample) begin
            for (int k = 0; k < BUCKETS; k++) begin
                if (adv && (n_idx_adv == IW'(k))) begin
                    r_bucket[k] <= dflt;
                end else if (fold && (r_idx == IW'(k))) begin
                    r_bucket[k] <= v;
                end
            end
            if (adv) begin
                r_idx  <= n_idx_adv;
                r_next <= n_next;
            end
        end
    end

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (do_sample) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_sample) begin
            r_out_data <= peak;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_window_value = r_out_data;

    // A restart returns the ring to its first bucket
    a_restart_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_restart |=> (r_idx == '0))
        else $error("bucket index not cleared by restart");

    // A fresh bucket after an advance holds the mode default
    a_adv_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_sample && adv) |=> (r_bucket[r_idx] == $past(dflt)))
        else $error("advanced bucket not cleared");

    // Min result never exceeds the folded sample, max never falls below it
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_sample && is_min) |=> (r_out_data <= $past(v)))
        else $error("minimum above sample");

    a_max_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_sample && !is_min) |=> (r_out_data >= $past(v)))
        else $error("maximum below sample");

endmodule

`default_nettype wire
